@@ src/bdq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg: shared constants and types for the bounded deque
// Sizes, command and status codes, controller/datapath interface structs,
// and the ring slot helper.
// ----------------------------------------------------------------------------
package bdq_pkg;

    // Ring geometry
    localparam int DEPTH  = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    // Command codes
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_REPLACE    = 3'd4;
    localparam logic [2:0] CMD_LIST       = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // Read address select
    localparam logic [1:0] RD_FRONT = 2'd0;
    localparam logic [1:0] RD_BACK  = 2'd1;
    localparam logic [1:0] RD_NEXT  = 2'd2;

    // Write address select
    localparam logic [1:0] WR_FRONT = 2'd0;
    localparam logic [1:0] WR_BACK  = 2'd1;
    localparam logic [1:0] WR_CUR   = 2'd2;

    // Pointer update
    localparam logic [2:0] PTR_NONE   = 3'd0;
    localparam logic [2:0] PTR_PUSH_F = 3'd1;
    localparam logic [2:0] PTR_PUSH_B = 3'd2;
    localparam logic [2:0] PTR_POP_F  = 3'd3;
    localparam logic [2:0] PTR_POP_B  = 3'd4;

    // Controller -> datapath
    typedef struct packed {
        logic       load_in;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       wr_en;
        logic [1:0] wr_sel;
        logic [2:0] ptr_op;
        logic       idx_clr;
        logic       idx_inc;
        logic       emit;
        logic       emit_rd;
        logic [1:0] emit_status;
        logic       emit_last;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       empty;
        logic       full;
        logic       match;
        logic       walk_last;
        logic       out_free;
    } t_dp_stat;

    // Slot of an offset from the front; front < DEPTH and offset <= DEPTH
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
                                                  input logic [CNT_W-1:0] offset);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - IDX_W){1'b0}}, front} + {1'b0, offset};
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

@@ src/bdq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_ctrl: command sequencer
// Takes one command word at a time, dispatches it, and steps the datapath
// through pops and through the entry walk used by replace and list.
// ----------------------------------------------------------------------------
module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DISP = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;
    localparam logic [1:0] S_WALK = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.emit_last = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DISP;
                end
            end

            S_DISP: begin
                unique case (i_stat.cmd)
                    CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                        if (i_stat.out_free) begin
                            o_cmd.emit = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.emit_status = ST_FULL;
                            end else begin
                                o_cmd.emit_status = ST_OK;
                                o_cmd.wr_en       = 1'b1;
                                if (i_stat.cmd == CMD_PUSH_FRONT) begin
                                    o_cmd.wr_sel = WR_FRONT;
                                    o_cmd.ptr_op = PTR_PUSH_F;
                                end else begin
                                    o_cmd.wr_sel = WR_BACK;
                                    o_cmd.ptr_op = PTR_PUSH_B;
                                end
                            end
                            n_state = S_IDLE;
                        end
                    end
                    CMD_POP_FRONT, CMD_POP_BACK: begin
                        if (i_stat.empty) begin
                            if (i_stat.out_free) begin
                                o_cmd.emit        = 1'b1;
                                o_cmd.emit_status = ST_EMPTY;
                                n_state           = S_IDLE;
                            end
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = (i_stat.cmd == CMD_POP_FRONT) ? RD_FRONT : RD_BACK;
                            n_state      = S_POP;
                        end
                    end
                    CMD_REPLACE, CMD_LIST: begin
                        if (i_stat.empty) begin
                            if (i_stat.out_free) begin
                                o_cmd.emit        = 1'b1;
                                o_cmd.emit_status = (i_stat.cmd == CMD_REPLACE) ?
                                                    ST_NOTFOUND : ST_EMPTY;
                                n_state           = S_IDLE;
                            end
                        end else begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_sel  = RD_FRONT;
                            o_cmd.idx_clr = 1'b1;
                            n_state       = S_WALK;
                        end
                    end
                    default: begin
                        // unused codes: no result
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_POP: begin
                if (i_stat.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_rd     = 1'b1;
                    o_cmd.emit_status = ST_OK;
                    o_cmd.ptr_op      = (i_stat.cmd == CMD_POP_FRONT) ? PTR_POP_F : PTR_POP_B;
                    n_state           = S_IDLE;
                end
            end

            S_WALK: begin
                if (i_stat.cmd == CMD_REPLACE) begin
                    priority if (i_stat.match) begin
                        if (i_stat.out_free) begin
                            o_cmd.wr_en       = 1'b1;
                            o_cmd.wr_sel      = WR_CUR;
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = ST_OK;
                            n_state           = S_IDLE;
                        end
                    end else if (i_stat.walk_last) begin
                        if (i_stat.out_free) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = ST_NOTFOUND;
                            n_state           = S_IDLE;
                        end
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        o_cmd.rd_en   = 1'b1;
                        o_cmd.rd_sel  = RD_NEXT;
                    end
                end else begin
                    // list: one word per entry, as the output frees up
                    if (i_stat.out_free) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_rd     = 1'b1;
                        o_cmd.emit_status = ST_OK;
                        o_cmd.emit_last   = i_stat.walk_last;
                        if (i_stat.walk_last) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.idx_inc = 1'b1;
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_sel  = RD_NEXT;
                        end
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/bdq_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_dpath: deque datapath
// Entry ring memory with registered read, front index, entry count, walk
// index, latched command word and the result output register.
// ----------------------------------------------------------------------------
module bdq_dpath
    import bdq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [2:0]               i_cmd,
    input  logic signed [WORD_W-1:0] i_value,
    input  logic signed [WORD_W-1:0] i_new_value,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic signed [WORD_W-1:0] o_data,
    output logic [1:0]               o_status,
    output logic                     o_last,
    input  t_dp_cmd                  i_ctl,
    output t_dp_stat                 o_stat
);

    logic signed [WORD_W-1:0] r_mem [DEPTH];
    logic signed [WORD_W-1:0] r_rd_data;

    logic [2:0]               r_cmd;
    logic signed [WORD_W-1:0] r_value;
    logic signed [WORD_W-1:0] r_new_value;

    logic [IDX_W-1:0] r_front;
    logic [IDX_W-1:0] n_front;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] idx_next;

    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] front_inc;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic signed [WORD_W-1:0] wr_data;

    logic                     r_out_valid;
    logic signed [WORD_W-1:0] r_out_data;
    logic [1:0]               r_out_status;
    logic                     r_out_last;
    logic                     out_free;

    // Latch the command word
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_cmd       <= i_cmd;
            r_value     <= i_value;
            r_new_value <= i_new_value;
        end
    end

    // Address arithmetic
    assign idx_next  = CNT_W'(r_idx + 1'b1);
    assign front_dec = (r_front == '0) ? IDX_W'(DEPTH - 1) : IDX_W'(r_front - 1'b1);
    assign front_inc = slot_of(r_front, CNT_W'(1));

    always_comb begin
        unique case (i_ctl.rd_sel)
            RD_FRONT: rd_addr = r_front;
            RD_BACK:  rd_addr = slot_of(r_front, CNT_W'(r_count - 1'b1));
            RD_NEXT:  rd_addr = slot_of(r_front, idx_next);
            default:  rd_addr = r_front;
        endcase
    end

    always_comb begin
        unique case (i_ctl.wr_sel)
            WR_FRONT: wr_addr = front_dec;
            WR_BACK:  wr_addr = slot_of(r_front, r_count);
            WR_CUR:   wr_addr = slot_of(r_front, r_idx);
            default:  wr_addr = front_dec;
        endcase
    end

    assign wr_data = (i_ctl.wr_sel == WR_CUR) ? r_new_value : r_value;

    // Entry memory
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Front index and count
    always_comb begin
        n_front = r_front;
        n_count = r_count;
        unique case (i_ctl.ptr_op)
            PTR_PUSH_F: begin
                n_front = front_dec;
                n_count = CNT_W'(r_count + 1'b1);
            end
            PTR_PUSH_B: n_count = CNT_W'(r_count + 1'b1);
            PTR_POP_F: begin
                n_front = front_inc;
                n_count = CNT_W'(r_count - 1'b1);
            end
            PTR_POP_B:  n_count = CNT_W'(r_count - 1'b1);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    // Walk index
    always_ff @(posedge i_clk) begin
        if (i_ctl.idx_clr) begin
            r_idx <= '0;
        end else if (i_ctl.idx_inc) begin
            r_idx <= idx_next;
        end
    end

    // Output register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_out_data   <= i_ctl.emit_rd ? r_rd_data : '0;
            r_out_status <= i_ctl.emit_status;
            r_out_last   <= i_ctl.emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data      = r_out_data;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

    // Status to controller
    assign o_stat.cmd       = r_cmd;
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count >= CNT_W'(DEPTH));
    assign o_stat.match     = (r_rd_data == r_value);
    assign o_stat.walk_last = (idx_next == r_count);
    assign o_stat.out_free  = out_free;

endmodule

@@ src/bounded_deque_with_replace.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_replace: bounded deque of signed 32-bit words
// Push/pop at either end, replace first match, list all entries.
// ----------------------------------------------------------------------------
// One command word is taken at a time; o_in_ready is high only while the
// sequencer is idle. Push writes the ring and answers from the dispatch
// state. Pop goes through an extra state for the registered memory read.
// Replace walks the ring from the front, reading one ring entry per cycle
// through the single memory read port, and stops at the first match or
// after the last entry. List returns one result word per entry, one result
// word per cycle when the consumer keeps up. A full ring drops the pushed
// word and answers with status full; the result register lets the next
// command be taken while a result word waits to be read.
// ----------------------------------------------------------------------------
module bounded_deque_with_replace
    import bdq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [2:0]               i_cmd,
    input  logic signed [WORD_W-1:0] i_value,
    input  logic signed [WORD_W-1:0] i_new_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [WORD_W-1:0] o_data,
    output logic [1:0]               o_status,
    output logic                     o_last
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer
    bdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // Storage and result path
    bdq_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .i_new_value (i_new_value),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_data      (o_data),
        .o_status    (o_status),
        .o_last      (o_last),
        .i_ctl       (dp_cmd),
        .o_stat      (dp_stat)
    );

endmodule

@@ src/bdq_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_chk: port-level checks for the bounded deque
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module bdq_chk
    import bdq_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic signed [WORD_W-1:0] o_data,
    input logic [1:0]               o_status,
    input logic                     o_last
);

    // No result word right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid right after reset");

    // One command at a time: ready drops after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("command word taken while one is in flight");

    // Any error status ends its command
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_last)
        else $error("error status on a non-final word");

    // Error results carry zero data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_data == '0))
        else $error("error status with nonzero data");

    // Stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_data) && $stable(o_status) && $stable(o_last))
        else $error("stalled result word changed");

endmodule

bind bounded_deque_with_replace bdq_chk u_bdq_chk (.*);
